>>> rtl/core/deadline_ordered_work_queue_defines.svh
// Assertion macros shared by the deadline ordered work queue RTL.
`ifndef DEADLINE_ORDERED_WORK_QUEUE_DEFINES_SVH
`define DEADLINE_ORDERED_WORK_QUEUE_DEFINES_SVH
`ifndef ASSERT_OFF
`define DOWQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("dowq assertion failed");
`define DOWQ_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("dowq assertion failed");
`else
`define DOWQ_ASSERT(lbl, prop)
`define DOWQ_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

>>> rtl/core/dowq_pkg.sv
// Types and constants of the deadline ordered work queue.
package dowq_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int ID_W      = $clog2(NUM_SLOTS);
  localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
  localparam int TIME_W    = 64;

  typedef enum logic [2:0] {
    MODE_QUEUE  = 3'd0,
    MODE_DELAY  = 3'd1,
    MODE_CANCEL = 3'd2,
    MODE_TICK   = 3'd3,
    MODE_FINISH = 3'd4
  } dowq_mode_t;

  typedef enum logic [1:0] {
    SLOT_IDLE      = 2'd0,
    SLOT_QUEUED    = 2'd1,
    SLOT_RUNNING   = 2'd2,
    SLOT_CANCELING = 2'd3
  } dowq_slot_t;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_EXEC,
    SQ_EXPIRE,
    SQ_DISPATCH
  } dowq_fsm_t;

  typedef struct packed {
    logic [2:0]        mode;
    logic [3:0]        work_id;
    logic [TIME_W-1:0] delay_time;
    logic [TIME_W-1:0] current_time;
  } dowq_req_t;

  typedef struct packed {
    logic              request_ok;
    logic              cancel_wait;
    logic              dispatch_valid;
    logic [3:0]        dispatch_id;
    logic [TIME_W-1:0] wait_until;
    logic [4:0]        pending_count;
    logic              queue_idle;
  } dowq_res_t;

  // chain control: insert/push, pop head, drop matching id
  typedef struct packed {
    logic ins;
    logic pop;
    logic drop;
  } dowq_ctl_t;

  typedef struct packed {
    logic              valid;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] dl;
  } dowq_dent_t;

  typedef struct packed {
    logic            valid;
    logic [ID_W-1:0] id;
  } dowq_rent_t;

endpackage

>>> rtl/core/deadline_ordered_work_queue.sv
// Top level of the deadline ordered work queue.
// Usage: drive in_req and pulse start while busy is low; the request is taken
// at that edge. Modes: queue now, queue delayed, cancel, tick, finish.
// Each request gives exactly one result on out_res, marked by out_valid for
// one cycle; the receiver cannot stall it, so it must sample that cycle.
// Sequence: queue, cancel, finish and unused modes go from accept through
// the EXEC state, whose result is registered onto out_res with the strobe.
// A tick goes through EXPIRE, which moves the E expired delayed slots
// (0 to NUM_SLOTS) to the ready FIFO, one per cycle at the head of the
// deadline chain, and then DISPATCH, whose result is registered likewise.
// A new request is accepted in the cycle its predecessor's result is shown;
// none is taken before the last one has given its result.
// Both lists are chains of cells; an insert or a removal shifts the chain
// at once, each deadline cell comparing its own deadline with the new one.
// cfg_data bit 0 is accept_enable (reset 1); cfg_ready is always high and
// writes belong in idle time only.
// Reset (synchronous, rst_n low) empties both chains, idles all slots and
// clears counters; no clearing pass is needed.
`include "deadline_ordered_work_queue_defines.svh"
module deadline_ordered_work_queue import dowq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  dowq_req_t in_req,
  output logic      out_valid,
  output dowq_res_t out_res,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  dowq_fsm_t         state_r, state_nxt;
  dowq_req_t         req_r;
  logic [TIME_W-1:0] dl_r;
  logic              acc_en_r;
  logic [CNT_W-1:0]  outst_r, outst_nxt;
  logic              run_v_r, run_v_nxt;
  logic [ID_W-1:0]   run_id_r, run_id_nxt;
  dowq_slot_t        slot_st_r [NUM_SLOTS];
  logic [TIME_W-1:0] wu_r, wu_nxt;
  logic              out_valid_r, out_valid_nxt;
  dowq_res_t         out_r, out_nxt;

  logic              st_we;
  logic [ID_W-1:0]   st_idx;
  dowq_slot_t        st_val;
  dowq_slot_t        cur_st;
  logic [TIME_W:0]   dl_sum;

  dowq_ctl_t         dctl, rctl;
  logic [ID_W-1:0]   rdy_new_id;
  dowq_dent_t        dnew;
  dowq_dent_t        dq [NUM_SLOTS];
  dowq_rent_t        rq [NUM_SLOTS];
  logic              dins [NUM_SLOTS+1];
  logic              ddrop [NUM_SLOTS+1];
  logic              rdrop [NUM_SLOTS+1];

  assign busy      = (state_r != SQ_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_res   = out_r;
  assign cur_st    = slot_st_r[req_r.work_id[ID_W-1:0]];
  assign dl_sum    = {1'b0, in_req.current_time} + {1'b0, in_req.delay_time};
  assign dnew      = '{valid: 1'b1, id: req_r.work_id[ID_W-1:0], dl: dl_r};

  // deadline chain and ready FIFO chain
  assign dins[0]  = 1'b0;
  assign ddrop[0] = 1'b0;
  assign rdrop[0] = 1'b0;
  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cells
    dowq_dly_cell u_dly (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (dctl),
      .new_ent  (dnew),
      .left_ent ((i == 0) ? dowq_dent_t'('0) : dq[(i == 0) ? 0 : i-1]),
      .right_ent((i == NUM_SLOTS-1) ? dowq_dent_t'('0)
                                    : dq[(i == NUM_SLOTS-1) ? i : i+1]),
      .ins_in   (dins[i]),
      .drop_in  (ddrop[i]),
      .key_id   (req_r.work_id[ID_W-1:0]),
      .ent      (dq[i]),
      .ins_out  (dins[i+1]),
      .drop_out (ddrop[i+1])
    );
    dowq_rdy_cell u_rdy (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (rctl),
      .new_id    (rdy_new_id),
      .left_valid((i == 0) ? 1'b1 : rq[(i == 0) ? 0 : i-1].valid),
      .right_ent ((i == NUM_SLOTS-1) ? dowq_rent_t'('0)
                                     : rq[(i == NUM_SLOTS-1) ? i : i+1]),
      .drop_in   (rdrop[i]),
      .key_id    (req_r.work_id[ID_W-1:0]),
      .ent       (rq[i]),
      .drop_out  (rdrop[i+1])
    );
  end

  // sequencer: next state, chain controls, slot state write, result
  always_comb begin
    state_nxt     = state_r;
    dctl          = '0;
    rctl          = '0;
    rdy_new_id    = req_r.work_id[ID_W-1:0];
    st_we         = 1'b0;
    st_idx        = req_r.work_id[ID_W-1:0];
    st_val        = SLOT_IDLE;
    outst_nxt     = outst_r;
    run_v_nxt     = run_v_r;
    run_id_nxt    = run_id_r;
    wu_nxt        = wu_r;
    out_valid_nxt = 1'b0;
    out_nxt       = '0;
    case (state_r)
      SQ_IDLE: begin
        if (start) state_nxt = (in_req.mode == MODE_TICK) ? SQ_EXPIRE : SQ_EXEC;
      end
      SQ_EXEC: begin
        case (req_r.mode)
          MODE_QUEUE, MODE_DELAY: begin
            if (acc_en_r && cur_st == SLOT_IDLE) begin
              st_we              = 1'b1;
              st_val             = SLOT_QUEUED;
              outst_nxt          = outst_r + CNT_W'(1);
              out_nxt.request_ok = 1'b1;
              if (req_r.mode == MODE_QUEUE) rctl.ins = 1'b1;
              else dctl.ins = 1'b1;
            end
          end
          MODE_CANCEL: begin
            if (cur_st == SLOT_QUEUED) begin
              dctl.drop          = 1'b1;
              rctl.drop          = 1'b1;
              st_we              = 1'b1;
              st_val             = SLOT_IDLE;
              if (outst_r != '0) outst_nxt = outst_r - CNT_W'(1);
              out_nxt.request_ok = 1'b1;
            end else if (cur_st == SLOT_RUNNING || cur_st == SLOT_CANCELING) begin
              st_we               = 1'b1;
              st_val              = SLOT_CANCELING;
              out_nxt.cancel_wait = 1'b1;
            end
          end
          MODE_FINISH: begin
            if (run_v_r) begin
              st_we     = 1'b1;
              st_idx    = run_id_r;
              st_val    = SLOT_IDLE;
              run_v_nxt = 1'b0;
              if (outst_r != '0) outst_nxt = outst_r - CNT_W'(1);
            end
          end
          default: ;
        endcase
        out_valid_nxt = 1'b1;
        state_nxt     = SQ_IDLE;
      end
      SQ_EXPIRE: begin
        // move one expired head per cycle to the ready tail
        if (dq[0].valid && !(dq[0].dl > req_r.current_time)) begin
          dctl.pop   = 1'b1;
          rctl.ins   = 1'b1;
          rdy_new_id = dq[0].id;
        end else begin
          wu_nxt    = dq[0].valid ? dq[0].dl : '0;
          state_nxt = SQ_DISPATCH;
        end
      end
      SQ_DISPATCH: begin
        if (!run_v_r && rq[0].valid) begin
          rctl.pop               = 1'b1;
          st_we                  = 1'b1;
          st_idx                 = rq[0].id;
          st_val                 = SLOT_RUNNING;
          run_v_nxt              = 1'b1;
          run_id_nxt             = rq[0].id;
          out_nxt.dispatch_valid = 1'b1;
          out_nxt.dispatch_id    = 4'(rq[0].id);
        end
        out_nxt.wait_until = wu_r;
        out_valid_nxt      = 1'b1;
        state_nxt          = SQ_IDLE;
      end
      default: state_nxt = SQ_IDLE;
    endcase
    out_nxt.pending_count = 5'(outst_nxt);
    out_nxt.queue_idle    = (outst_nxt == '0);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SQ_IDLE;
      acc_en_r    <= 1'b1;
      outst_r     <= '0;
      run_v_r     <= 1'b0;
      run_id_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      outst_r     <= outst_nxt;
      run_v_r     <= run_v_nxt;
      run_id_r    <= run_id_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) acc_en_r <= cfg_data;
    end
  end

  // request capture with saturated deadline; wait-until and result registers
  always_ff @(posedge clk) begin
    if (state_r == SQ_IDLE && start) begin
      req_r <= in_req;
      dl_r  <= dl_sum[TIME_W] ? {TIME_W{1'b1}} : dl_sum[TIME_W-1:0];
    end
    wu_r  <= wu_nxt;
    out_r <= out_nxt;
  end

  // per-slot state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NUM_SLOTS; s++) slot_st_r[s] <= SLOT_IDLE;
    end else if (st_we) begin
      slot_st_r[st_idx] <= st_val;
    end
  end

  `DOWQ_ASSERT(a_run_slot, run_v_r |-> (slot_st_r[run_id_r] == SLOT_RUNNING || slot_st_r[run_id_r] == SLOT_CANCELING))
  `DOWQ_ASSERT(a_accept_busy, (start && !busy) |=> busy)
  `DOWQ_ASSERT(a_flags_excl, out_valid |-> !(out_res.request_ok && out_res.cancel_wait))
  `DOWQ_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid && !busy)

endmodule

>>> rtl/core/dowq_dly_cell.sv
// One cell of the deadline sorted chain.
module dowq_dly_cell import dowq_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  dowq_ctl_t       ctl,
  input  dowq_dent_t      new_ent,
  input  dowq_dent_t      left_ent,
  input  dowq_dent_t      right_ent,
  input  logic            ins_in,
  input  logic            drop_in,
  input  logic [ID_W-1:0] key_id,
  output dowq_dent_t      ent,
  output logic            ins_out,
  output logic            drop_out
);

  dowq_dent_t ent_r, ent_nxt;
  logic       ins_here;

  // new entry belongs at or before this cell (strict: equal deadlines stay ahead)
  assign ins_here = !ent_r.valid || (new_ent.dl < ent_r.dl);
  assign ins_out  = ins_here;
  assign drop_out = drop_in || (ent_r.valid && (ent_r.id == key_id));
  assign ent      = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (ctl.ins) begin
      if (ins_in) ent_nxt = left_ent;
      else if (ins_here) ent_nxt = new_ent;
    end else if (ctl.pop) begin
      ent_nxt = right_ent;
    end else if (ctl.drop && drop_out) begin
      ent_nxt = right_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
    end else begin
      ent_r <= ent_nxt;
    end
  end

endmodule

>>> rtl/core/dowq_rdy_cell.sv
// One cell of the ready FIFO chain.
module dowq_rdy_cell import dowq_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  dowq_ctl_t       ctl,
  input  logic [ID_W-1:0] new_id,
  input  logic            left_valid,
  input  dowq_rent_t      right_ent,
  input  logic            drop_in,
  input  logic [ID_W-1:0] key_id,
  output dowq_rent_t      ent,
  output logic            drop_out
);

  dowq_rent_t ent_r, ent_nxt;

  assign drop_out = drop_in || (ent_r.valid && (ent_r.id == key_id));
  assign ent      = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (ctl.ins) begin
      // first empty cell takes the tail push
      if (!ent_r.valid && left_valid) ent_nxt = '{valid: 1'b1, id: new_id};
    end else if (ctl.pop) begin
      ent_nxt = right_ent;
    end else if (ctl.drop && drop_out) begin
      ent_nxt = right_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
    end else begin
      ent_r <= ent_nxt;
    end
  end

endmodule
